// ===== hw/rtl/rtoc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath types for the region table.
package rtoc_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_BITS   = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OP_W        = 3;
  localparam int KEY_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 4;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_OVERLAP = 3'd2;
  localparam logic [OP_W-1:0] OP_CONTAIN = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                accept;
    logic                add_write;
    logic                scan_step;
    logic                hit;
    logic                move;
    logic                set_none;
    logic [STATUS_W-1:0] status;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            scan_end;
    logic            exact;
    logic            overlap;
    logic            key_diff;
  } sts_t;

endpackage

// ===== hw/rtl/rtoc_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the region table.
interface rtoc_req_if;
  logic                          valid;
  logic                          ready;
  logic [rtoc_pkg::OP_W-1:0]     opcode;
  logic [rtoc_pkg::ADDR_BITS-1:0] start_req;
  logic [rtoc_pkg::ADDR_BITS-1:0] length;
  logic [rtoc_pkg::KEY_W-1:0]    key;

  modport source (output valid, opcode, start_req, length, key, input ready);
  modport sink (input valid, opcode, start_req, length, key, output ready);
endinterface

interface rtoc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rtoc_pkg::STATUS_W-1:0]  status;
  logic [rtoc_pkg::SLOT_W-1:0]    slot;
  logic [rtoc_pkg::ADDR_BITS-1:0] found_start;
  logic [rtoc_pkg::ADDR_BITS-1:0] found_length;
  logic [rtoc_pkg::KEY_W-1:0]     found_key;

  modport source (output valid, status, slot, found_start, found_length, found_key,
                  input ready);
  modport sink (input valid, status, slot, found_start, found_length, found_key,
                output ready);
endinterface

// ===== hw/rtl/region_table_overlap_check.sv =====
`timescale 1ns / 1ps
// Top level of the memory region table with overlap and key checking.
// One request beat is handled at a time. An add, or any request with an unknown
// opcode, sets its result in the execute state and loads it in the finish state; remove
// and the three lookups walk the table one entry per cycle through a single read port,
// and a remove that hits then moves the last entry into the freed slot. The next request
// beat is accepted in the cycle after the result is loaded. Results wait in an output
// register, so the next request beat is accepted while a response beat is still pending;
// a finished result that finds that register still occupied waits until the pending
// response beat is taken. The table needs no clearing after reset.
module region_table_overlap_check (
  input logic         clk,
  input logic         rst,
  rtoc_req_if.sink    req,
  rtoc_rsp_if.source  rsp
);
  import rtoc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rtoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtoc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (req.opcode),
    .start_req    (req.start_req),
    .length       (req.length),
    .key          (req.key),
    .status       (rsp.status),
    .slot         (rsp.slot),
    .found_start  (rsp.found_start),
    .found_length (rsp.found_length),
    .found_key    (rsp.found_key)
  );

endmodule

// ===== hw/rtl/rtoc_datapath.sv =====
`timescale 1ns / 1ps
// Region table storage, request registers, scan compare and result registers.
module rtoc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  rtoc_pkg::cmd_t                 cmd,
  output rtoc_pkg::sts_t                 sts,
  input  logic [rtoc_pkg::OP_W-1:0]      opcode,
  input  logic [rtoc_pkg::ADDR_BITS-1:0] start_req,
  input  logic [rtoc_pkg::ADDR_BITS-1:0] length,
  input  logic [rtoc_pkg::KEY_W-1:0]     key,
  output logic [rtoc_pkg::STATUS_W-1:0]  status,
  output logic [rtoc_pkg::SLOT_W-1:0]    slot,
  output logic [rtoc_pkg::ADDR_BITS-1:0] found_start,
  output logic [rtoc_pkg::ADDR_BITS-1:0] found_length,
  output logic [rtoc_pkg::KEY_W-1:0]     found_key
);
  import rtoc_pkg::*;

  logic [ADDR_BITS-1:0] entry_start  [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] entry_length [TABLE_DEPTH];
  logic [KEY_W-1:0]     entry_key    [TABLE_DEPTH];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;

  logic [OP_W-1:0]      op;
  logic [ADDR_BITS-1:0] needle_start;
  logic [ADDR_BITS-1:0] needle_length;
  logic [ADDR_BITS:0]   needle_end;
  logic [KEY_W-1:0]     key_exp;

  logic [STATUS_W-1:0]  res_status;
  logic [IDX_W-1:0]     res_slot;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS-1:0] res_length;
  logic [KEY_W-1:0]     res_key;

  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_length;
  logic [KEY_W-1:0]     rd_key;
  logic [ADDR_BITS:0]   rd_end;
  logic [ADDR_BITS-1:0] eff_length;

  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign rd_addr   = cmd.move ? last_idx : idx[IDX_W-1:0];
  assign rd_start  = entry_start[rd_addr];
  assign rd_length = entry_length[rd_addr];
  assign rd_key    = entry_key[rd_addr];
  assign rd_end    = {1'b0, rd_start} + {1'b0, rd_length};

  // A containing-address lookup searches with a zero-length needle.
  assign eff_length = (opcode == OP_CONTAIN) ? '0 : length;

  always_comb begin
    sts.op       = op;
    sts.full     = count >= CNT_W'(TABLE_DEPTH);
    sts.scan_end = idx >= count;
    sts.exact    = (rd_start == needle_start) && (rd_length == needle_length);
    sts.overlap  = (rd_end >= {1'b0, needle_start}) && (needle_end >= {1'b0, rd_start});
    sts.key_diff = rd_key != key_exp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.add_write) begin
        count <= count + CNT_W'(1);
      end else if (cmd.move) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      entry_start[count[IDX_W-1:0]]  <= needle_start;
      entry_length[count[IDX_W-1:0]] <= needle_length;
      entry_key[count[IDX_W-1:0]]    <= key_exp;
    end else if (cmd.move) begin
      entry_start[res_slot]  <= rd_start;
      entry_length[res_slot] <= rd_length;
      entry_key[res_slot]    <= rd_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op            <= opcode;
      needle_start  <= start_req;
      needle_length <= length;
      needle_end    <= {1'b0, start_req} + {1'b0, eff_length};
      key_exp       <= key;
    end
    if (cmd.add_write) begin
      res_status <= ST_OK;
      res_slot   <= count[IDX_W-1:0];
      res_start  <= needle_start;
      res_length <= needle_length;
      res_key    <= key_exp;
    end else if (cmd.hit) begin
      res_status <= cmd.status;
      res_slot   <= idx[IDX_W-1:0];
      res_start  <= rd_start;
      res_length <= rd_length;
      res_key    <= rd_key;
    end else if (cmd.set_none) begin
      res_status <= cmd.status;
      res_slot   <= '0;
      res_start  <= '0;
      res_length <= '0;
      res_key    <= '0;
    end
    if (cmd.load_out) begin
      status       <= res_status;
      slot         <= SLOT_W'(res_slot);
      found_start  <= res_start;
      found_length <= res_length;
      found_key    <= res_key;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_add_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |-> !sts.full)
    else $error("entry written into a full table");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |=> count == $past(count) + CNT_W'(1))
    else $error("add did not grow the table by one");

  a_move_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.move |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the table by one");
`endif

endmodule

// ===== hw/rtl/rtoc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine and output register valid flag for the region table.
module rtoc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  rtoc_pkg::sts_t sts,
  output rtoc_pkg::cmd_t cmd
);
  import rtoc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  assign rsp_valid      = out_valid;
  assign out_valid_next = cmd.load_out | (out_valid & ~rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_ADD: begin
            if (sts.full) begin
              cmd.set_none = 1'b1;
              cmd.status   = ST_FULL;
            end else begin
              cmd.add_write = 1'b1;
            end
            state_next = S_FINISH;
          end
          OP_REMOVE, OP_OVERLAP, OP_CONTAIN, OP_CHECK: begin
            if (sts.scan_end) begin
              cmd.set_none = 1'b1;
              cmd.status   = (sts.op == OP_CHECK) ? ST_OK : ST_MISS;
              state_next   = S_FINISH;
            end else if (sts.op == OP_REMOVE && sts.exact) begin
              cmd.hit    = 1'b1;
              cmd.status = ST_OK;
              state_next = S_MOVE;
            end else if ((sts.op == OP_OVERLAP || sts.op == OP_CONTAIN) && sts.overlap) begin
              cmd.hit    = 1'b1;
              cmd.status = ST_OK;
              state_next = S_FINISH;
            end else if (sts.op == OP_CHECK && sts.overlap && sts.key_diff) begin
              cmd.hit    = 1'b1;
              cmd.status = ST_MISS;
              state_next = S_FINISH;
            end else begin
              cmd.scan_step = 1'b1;
            end
          end
          default: begin
            cmd.set_none = 1'b1;
            cmd.status   = ST_MISS;
            state_next   = S_FINISH;
          end
        endcase
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
